@@ src/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg: shared types and constants of the fixed block pool allocator
// Holds the payload structs, status and register codes, and sequencer states.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int ADDR_W     = 32;
  localparam int REQ_W      = 17;
  localparam int BS_W       = REQ_W + 1;
  localparam int CNT_W      = 11;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Smallest block before rounding, and the rounding mask for 16-byte steps.
  localparam logic [REQ_W-1:0] MIN_BLOCK_BYTES = REQ_W'(8);
  localparam logic [BS_W-1:0]  BLOCK_ROUND     = BS_W'(15);

  // Reset values of the configuration registers.
  localparam logic [REQ_W-1:0]  RST_REQ_SIZE = REQ_W'(16);
  localparam logic [CNT_W-1:0]  RST_ACTIVE   = CNT_W'(1024);
  localparam logic [ADDR_W-1:0] RST_BASE     = ADDR_W'(65536);

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_TOO_LARGE   = 3'd1,
    STATUS_EXHAUSTED   = 3'd2,
    STATUS_ADDR_REJECT = 3'd3,
    STATUS_NONE_IN_USE = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REQ_SIZE = 2'd0,
    CFG_ACTIVE   = 2'd1,
    CFG_BASE     = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP,
    ST_MUL,
    ST_ADDBASE,
    ST_SUBBASE,
    ST_RANGE,
    ST_DIV,
    ST_CHECK,
    ST_RESP
  } core_state_e;

  typedef struct packed {
    logic              cmd;
    logic [REQ_W-1:0]  request_size;
    logic [ADDR_W-1:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] block_address;
    logic [CNT_W-1:0]  in_use_count;
    logic [CNT_W-1:0]  peak_count;
  } out_item_t;

  // Pool setup as seen by the sequencer.
  typedef struct packed {
    logic [BS_W-1:0]   block_bytes;
    logic [CNT_W-1:0]  pool_count;
    logic [ADDR_W-1:0] base;
    logic              reinit;
  } pool_cfg_t;

endpackage

@@ src/fbpa_alu.sv @@
// ----------------------------------------------------------------------------
// fbpa_alu: shared shift and add/subtract unit
// Adds or subtracts a left-shifted operand; reports carry or borrow.
// ----------------------------------------------------------------------------
module fbpa_alu #(
  parameter int SHIFT_W = 4
) (
  input  logic [fbpa_pkg::ADDR_W-1:0] a_i,
  input  logic [fbpa_pkg::ADDR_W-1:0] b_i,
  input  logic [SHIFT_W-1:0]          shamt_i,
  input  fbpa_pkg::alu_op_e           op_i,
  output logic [fbpa_pkg::ADDR_W-1:0] res_o,
  output logic                        borrow_o
);
  import fbpa_pkg::*;

  logic [ADDR_W-1:0] b_sh;
  logic [ADDR_W:0]   full;

  always_comb begin
    b_sh = b_i << shamt_i;
    if (op_i == ALU_SUB) begin
      full = {1'b0, a_i} - {1'b0, b_sh};
    end else begin
      full = {1'b0, a_i} + {1'b0, b_sh};
    end
  end

  assign res_o    = full[ADDR_W-1:0];
  assign borrow_o = full[ADDR_W];

endmodule

@@ src/fbpa_stack.sv @@
// ----------------------------------------------------------------------------
// fbpa_stack: storage for the free-block index stack
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module fbpa_stack #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 10
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/fbpa_core.sv @@
// ----------------------------------------------------------------------------
// fbpa_core: allocate/free sequencer
// Runs shift-add multiply and restoring divide on the shared unit.
// ----------------------------------------------------------------------------
module fbpa_core #(
  parameter int CAP = 1024,
  parameter int IW  = 10,
  parameter int SW  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fbpa_pkg::pool_cfg_t   cfg_i,
  input  logic                  req_valid_i,
  input  fbpa_pkg::in_item_t    req_i,
  output logic                  busy_o,
  output logic                  resp_valid_o,
  input  logic                  resp_ready_i,
  output fbpa_pkg::out_item_t   resp_o
);
  import fbpa_pkg::*;

  localparam logic [SW-1:0] STEP_TOP   = SW'(IW - 1);
  localparam logic [SW-1:0] STEP_LIMIT = SW'(IW);

  core_state_e       state_q, state_d;
  logic [ADDR_W-1:0] work_q, work_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [SW-1:0]     step_q, step_d;
  status_e           status_q, status_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic [CNT_W-1:0]  depth_q, depth_d;
  logic [CNT_W-1:0]  fresh_q, fresh_d;
  logic [CNT_W-1:0]  in_use_q, in_use_d;
  logic [CNT_W-1:0]  peak_q, peak_d;
  logic [CNT_W-1:0]  in_use_inc;

  logic [ADDR_W-1:0] alu_b;
  logic [SW-1:0]     alu_shamt;
  alu_op_e           alu_op;
  logic [ADDR_W-1:0] alu_res;
  logic              alu_borrow;

  logic              st_rd_en, st_wr_en;
  logic [IW-1:0]     st_rd_data;
  logic [IW-1:0]     st_rd_addr;
  logic [ADDR_W-1:0] bs_ext;

  assign bs_ext     = ADDR_W'(cfg_i.block_bytes);
  assign in_use_inc = in_use_q + 1'b1;
  assign st_rd_addr = depth_d[IW-1:0];

  fbpa_alu #(.SHIFT_W(SW)) u_alu (
    .a_i      (work_q),
    .b_i      (alu_b),
    .shamt_i  (alu_shamt),
    .op_i     (alu_op),
    .res_o    (alu_res),
    .borrow_o (alu_borrow)
  );

  fbpa_stack #(.DEPTH(CAP), .AW(IW), .DW(IW)) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (st_wr_en),
    .wr_addr_i (depth_q[IW-1:0]),
    .wr_data_i (idx_q),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (st_rd_addr),
    .rd_data_o (st_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      depth_q  <= '0;
      fresh_q  <= '0;
      in_use_q <= '0;
      peak_q   <= '0;
    end else begin
      state_q  <= state_d;
      depth_q  <= depth_d;
      fresh_q  <= fresh_d;
      in_use_q <= in_use_d;
      peak_q   <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    idx_q      <= idx_d;
    step_q     <= step_d;
    status_q   <= status_d;
    res_addr_q <= res_addr_d;
  end

  always_comb begin
    state_d      = state_q;
    work_d       = work_q;
    idx_d        = idx_q;
    step_d       = step_q;
    status_d     = status_q;
    res_addr_d   = res_addr_q;
    depth_d      = depth_q;
    fresh_d      = fresh_q;
    in_use_d     = in_use_q;
    peak_d       = peak_q;
    alu_b        = bs_ext;
    alu_shamt    = step_q;
    alu_op       = ALU_ADD;
    st_rd_en     = 1'b0;
    st_wr_en     = 1'b0;
    resp_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          status_d   = STATUS_OK;
          res_addr_d = '0;
          if (req_i.cmd == CMD_FREE) begin
            work_d  = req_i.free_address;
            state_d = ST_SUBBASE;
          end else if (BS_W'(req_i.request_size) > cfg_i.block_bytes) begin
            status_d = STATUS_TOO_LARGE;
            state_d  = ST_RESP;
          end else if (depth_q != '0) begin
            // pop: read the entry below the current depth
            depth_d  = depth_q - 1'b1;
            st_rd_en = 1'b1;
            state_d  = ST_POP;
          end else if (fresh_q < cfg_i.pool_count) begin
            idx_d   = fresh_q[IW-1:0];
            fresh_d = fresh_q + 1'b1;
            work_d  = '0;
            step_d  = STEP_TOP;
            state_d = ST_MUL;
          end else begin
            status_d = STATUS_EXHAUSTED;
            state_d  = ST_RESP;
          end
        end
      end
      ST_POP: begin
        idx_d   = st_rd_data;
        work_d  = '0;
        step_d  = STEP_TOP;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        // add block size shifted by the current index bit, MSB first
        if (idx_q[IW-1]) begin
          work_d = alu_res;
        end
        idx_d = IW'({idx_q, 1'b0});
        if (step_q == '0) begin
          state_d = ST_ADDBASE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_ADDBASE: begin
        alu_b      = cfg_i.base;
        alu_shamt  = '0;
        res_addr_d = alu_res;
        in_use_d   = in_use_inc;
        if (in_use_inc > peak_q) begin
          peak_d = in_use_inc;
        end
        state_d = ST_RESP;
      end
      ST_SUBBASE: begin
        alu_b     = cfg_i.base;
        alu_shamt = '0;
        alu_op    = ALU_SUB;
        if (work_q == '0 || alu_borrow) begin
          status_d = STATUS_ADDR_REJECT;
          state_d  = ST_RESP;
        end else begin
          work_d  = alu_res;
          state_d = ST_RANGE;
        end
      end
      ST_RANGE: begin
        // offset beyond every representable quotient lies outside the pool
        alu_shamt = STEP_LIMIT;
        alu_op    = ALU_SUB;
        if (!alu_borrow) begin
          status_d = STATUS_ADDR_REJECT;
          state_d  = ST_RESP;
        end else begin
          idx_d   = '0;
          step_d  = STEP_TOP;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        alu_op = ALU_SUB;
        if (!alu_borrow) begin
          work_d = alu_res;
        end
        idx_d = IW'({idx_q, ~alu_borrow});
        if (step_q == '0) begin
          state_d = ST_CHECK;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_CHECK: begin
        if (work_q != '0 || CNT_W'(idx_q) >= cfg_i.pool_count) begin
          status_d = STATUS_ADDR_REJECT;
        end else if (in_use_q == '0) begin
          status_d = STATUS_NONE_IN_USE;
        end else begin
          st_wr_en = 1'b1;
          depth_d  = depth_q + 1'b1;
          in_use_d = in_use_q - 1'b1;
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        resp_valid_o = 1'b1;
        if (resp_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_i.reinit) begin
      depth_d  = '0;
      fresh_d  = '0;
      in_use_d = '0;
      peak_d   = '0;
    end
  end

  assign busy_o               = (state_q != ST_IDLE);
  assign resp_o.status        = status_q;
  assign resp_o.block_address = res_addr_q;
  assign resp_o.in_use_count  = in_use_q;
  assign resp_o.peak_count    = peak_q;

endmodule

@@ src/fixed_block_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator: fixed-size block pool with a free-index stack
// Configuration registers, sequencer and result register of the allocator.
// ----------------------------------------------------------------------------
// One transaction at a time: an allocate or free is taken when in_stall_o is
// low, and in_stall_o stays high until its result sits in the output
// register. IW = ceil(log2(min(MAX_BLOCKS, 2047))) (10 at the default) is
// the block index width. An allocate takes a fresh index or pops one from the
// stack memory (registered read); the single shared shift and add/subtract
// unit forms the block address one multiplier bit per cycle, then adds the
// base. A free subtracts the base, checks the range and runs a restoring
// divide, one quotient bit per cycle; a size failure or an exhausted pool
// goes straight to its result. The result register lets the next transaction
// enter while a result still waits downstream. The freed-index stack holds
// no reset state and needs no clearing pass; a write to active_blocks
// empties the pool at once. cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  fbpa_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output fbpa_pkg::out_item_t              out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import fbpa_pkg::*;

  // Pool size is capped by the parameter and by what the count fields hold.
  localparam int CAP = (MAX_BLOCKS > (2 ** CNT_W) - 1) ? (2 ** CNT_W) - 1 : MAX_BLOCKS;
  localparam int IW  = $clog2(CAP);
  localparam int SW  = $clog2(IW + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

  logic [REQ_W-1:0]  req_size_q;
  logic [CNT_W-1:0]  active_q;
  logic [ADDR_W-1:0] base_q;
  logic              cfg_we;
  logic [REQ_W-1:0]  size_floor;
  logic [BS_W-1:0]   size_round;
  pool_cfg_t         pool_cfg;

  logic              core_busy;
  logic              resp_valid;
  logic              resp_ready;
  out_item_t         resp;
  logic              out_valid_q;
  out_item_t         out_data_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Hold the configuration registers; ignore indexes past the list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_size_q <= RST_REQ_SIZE;
      active_q   <= RST_ACTIVE;
      base_q     <= RST_BASE;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_REQ_SIZE: req_size_q <= cfg_data_i[REQ_W-1:0];
        CFG_ACTIVE:   active_q   <= cfg_data_i[CNT_W-1:0];
        CFG_BASE:     base_q     <= cfg_data_i[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Raise the size to the minimum, then round up to a 16-byte multiple.
  // The rounded size of the largest register value needs one extra bit.
  always_comb begin
    size_floor = (req_size_q < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : req_size_q;
    size_round = ({1'b0, size_floor} + BLOCK_ROUND) & ~BLOCK_ROUND;
  end

  assign pool_cfg.block_bytes = size_round;
  assign pool_cfg.pool_count  = (active_q > CAP_CNT) ? CAP_CNT : active_q;
  assign pool_cfg.base        = base_q;
  // Reinitialize the pool on every write of the block count.
  assign pool_cfg.reinit      = cfg_we && (cfg_index_i == CFG_ACTIVE);

  fbpa_core #(.CAP(CAP), .IW(IW), .SW(SW)) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (pool_cfg),
    .req_valid_i  (in_valid_i),
    .req_i        (in_data_i),
    .busy_o       (core_busy),
    .resp_valid_o (resp_valid),
    .resp_ready_i (resp_ready),
    .resp_o       (resp)
  );

  assign in_stall_o = core_busy;

  // Advance the result into the output register once it is empty or drained.
  assign resp_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_valid && resp_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_valid && resp_ready) begin
      out_data_q <= resp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ src/fbpa_checker.sv @@
// ----------------------------------------------------------------------------
// fbpa_checker: port-level checks of the fixed block pool allocator
// Watches the data channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module fbpa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_i,
  input fbpa_pkg::in_item_t  in_data_i,
  input logic                out_valid_i,
  input logic                out_stall_i,
  input fbpa_pkg::out_item_t out_data_i
);
  import fbpa_pkg::*;

  // A stalled request stays valid and unchanged.
  a_request_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_i |=> in_valid_i && $stable(in_data_i))
    else $error("stalled request changed");

  // An accepted transaction keeps the input side stalled in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("input not stalled after accepting a transaction");

  // A stalled result stays valid and unchanged.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  // The peak never falls below the current in-use count.
  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.in_use_count <= out_data_i.peak_count)
    else $error("in-use count above peak");

  // A failed transaction reports a null block address.
  a_fail_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status != STATUS_OK |-> out_data_i.block_address == '0)
    else $error("failed transaction returned an address");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

@@ tb/tb_fixed_block_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator: self-checking bench of the block pool allocator
// Drives allocate and free transactions through the valid/stall channels under
// random gaps and back-pressure, reprograms the pool between phases, and checks
// every reply against a bit-exact pool model kept in a scoreboard class.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpa_pkg::*;

  localparam int          HALF_PERIOD  = 5;
  localparam int          RESET_CYCLES = 8;
  // Rest well beyond the length of a free before reprogramming.
  localparam int          REST_CYCLES  = 24;
  localparam int          NUM_PHASES   = 10;
  localparam int          PHASE_ITEMS  = 48;
  localparam int          STACK_DEPTH  = 1024;
  localparam int          MAX_REPORTS  = 10;

  // --------------------------------------------------------------------------
  // Pool model and reply store
  // --------------------------------------------------------------------------
  class pool_scoreboard;
    logic [9:0]        freed_idx [STACK_DEPTH];
    int unsigned       freed_cnt;
    int unsigned       fresh_idx;
    int unsigned       live_cnt;
    int unsigned       live_peak;
    logic [REQ_W-1:0]  size_reg;
    logic [CNT_W-1:0]  blocks_reg;
    logic [ADDR_W-1:0] base_reg;
    out_item_t         expected_replies[$];
    int unsigned       mismatches;

    function new();
      size_reg   = RST_REQ_SIZE;
      blocks_reg = RST_ACTIVE;
      base_reg   = RST_BASE;
      mismatches = 0;
      clear_pool();
    endfunction

    function void clear_pool();
      freed_cnt = 0;
      fresh_idx = 0;
      live_cnt  = 0;
      live_peak = 0;
    endfunction

    function longint unsigned block_bytes();
      longint unsigned s;
      s = size_reg;
      if (s < 8) s = 8;
      return (s + 15) & ~64'd15;
    endfunction

    function int unsigned pool_count();
      return (blocks_reg > STACK_DEPTH) ? STACK_DEPTH : blocks_reg;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_REQ_SIZE: size_reg = val[REQ_W-1:0];
        CFG_ACTIVE: begin
          blocks_reg = val[CNT_W-1:0];
          clear_pool();
        end
        CFG_BASE: base_reg = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    // Advance the pool by one accepted request and queue the reply it causes.
    function void note_request(in_item_t req);
      longint unsigned bs, span, off, addr;
      int unsigned     cnt, idx;
      bit              got;
      logic [63:0]     sum;
      out_item_t       rep;
      bs  = block_bytes();
      cnt = pool_count();
      rep = '0;
      rep.status = STATUS_OK;
      idx = 0;
      got = 1'b0;
      if (req.cmd == CMD_ALLOC) begin
        if (longint'(req.request_size) > bs) begin
          rep.status = STATUS_TOO_LARGE;
        end else if (freed_cnt > 0) begin
          freed_cnt--;
          idx = freed_idx[freed_cnt];
          got = 1'b1;
        end else if (fresh_idx < cnt) begin
          idx = fresh_idx;
          fresh_idx++;
          got = 1'b1;
        end else begin
          rep.status = STATUS_EXHAUSTED;
        end
        if (got) begin
          sum = base_reg + idx * bs;
          rep.block_address = sum[ADDR_W-1:0];
          live_cnt++;
          if (live_cnt > live_peak) live_peak = live_cnt;
        end
      end else begin
        addr = req.free_address;
        span = bs * cnt;
        off  = addr - base_reg;
        if (addr == 0 || addr < base_reg || off >= span || (off % bs) != 0) begin
          rep.status = STATUS_ADDR_REJECT;
        end else if (live_cnt == 0) begin
          rep.status = STATUS_NONE_IN_USE;
        end else begin
          if (freed_cnt < STACK_DEPTH) begin
            freed_idx[freed_cnt] = 10'(off / bs);
            freed_cnt++;
          end
          live_cnt--;
        end
      end
      rep.in_use_count = live_cnt[CNT_W-1:0];
      rep.peak_count   = live_peak[CNT_W-1:0];
      expected_replies.push_back(rep);
    endfunction

    function void check_reply(out_item_t got);
      out_item_t exp;
      if (expected_replies.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected reply: status=%0d addr=%h in_use=%0d peak=%0d",
                   got.status, got.block_address, got.in_use_count, got.peak_count);
        mismatches++;
      end else begin
        exp = expected_replies.pop_front();
        if (got.status !== exp.status || got.block_address !== exp.block_address ||
            got.in_use_count !== exp.in_use_count || got.peak_count !== exp.peak_count)
        begin
          if (mismatches < MAX_REPORTS)
            $display("reply mismatch: exp status=%0d addr=%h in_use=%0d peak=%0d | %s",
                     exp.status, exp.block_address, exp.in_use_count, exp.peak_count,
                     $sformatf("got status=%0d addr=%h in_use=%0d peak=%0d", got.status,
                               got.block_address, got.in_use_count, got.peak_count));
          mismatches++;
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals
  // --------------------------------------------------------------------------
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_valid   = 1'b0;
  logic                   in_stall;
  in_item_t               in_data    = '0;
  logic                   out_valid;
  logic                   out_stall  = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  pool_scoreboard sb = new();

  // Stimulus shaping: burst phases drop every sender gap, calm phases drop
  // every receiver stall.
  bit          burst_mode  = 1'b0;
  logic        out_calm    = 1'b0;
  int unsigned stall_hold  = 0;
  int unsigned allocs_sent = 0;

  always #(HALF_PERIOD) clk = ~clk;

  fixed_block_pool_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Monitor: sample both channels on the clock edge, before any update lands.
  // Note the request first; a reply can never belong to the same edge's request.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_reply(out_data);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure: runs of free flow and stalls, mostly short stalls,
  // now and then a long one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : rx_stall_gen
    int unsigned r;
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (out_calm) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 29);
      end else if (r < 85) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(0, 2);
      end else if (r < 97) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(3, 14);
      end else begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(29, 79);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned next_gap();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Fill the ignored field with noise so every payload bit toggles.
  function automatic in_item_t alloc_item(int unsigned size);
    in_item_t it;
    it.cmd          = CMD_ALLOC;
    it.request_size = size[REQ_W-1:0];
    it.free_address = $urandom();
    return it;
  endfunction

  function automatic in_item_t free_item(logic [ADDR_W-1:0] addr);
    in_item_t it;
    it.cmd          = CMD_FREE;
    it.request_size = REQ_W'($urandom_range(0, 65536));
    it.free_address = addr;
    return it;
  endfunction

  // Mostly sizes that fit and frees of blocks that could be live, with a
  // share of oversize requests and malformed addresses.
  function automatic in_item_t random_item();
    in_item_t        it;
    longint unsigned bs;
    int unsigned     cnt, reach, slot, r;
    logic [63:0]     a;
    bs  = sb.block_bytes();
    cnt = sb.pool_count();
    r   = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 55) begin
      it = alloc_item($urandom_range(0, 65536));
      allocs_sent++;
      if (r < 70) it.request_size = REQ_W'($urandom_range(0, 32'(bs)));
      else if (r < 85 && bs < 65536)
        it.request_size = REQ_W'($urandom_range(32'(bs) + 1, 65536));
    end else begin
      reach = (allocs_sent < cnt) ? allocs_sent + 1 : cnt;
      slot  = (reach == 0) ? 0 : $urandom_range(0, reach - 1);
      if (r < 60)      a = sb.base_reg + slot * bs;
      else if (r < 70) a = sb.base_reg + (cnt + $urandom_range(0, 2)) * bs;
      else if (r < 82) a = sb.base_reg + slot * bs + $urandom_range(1, bs - 1);
      else if (r < 87) a = '0;
      else             a = $urandom();
      it = free_item(a[ADDR_W-1:0]);
    end
    return it;
  endfunction

  // Present one request after an optional gap; return on the accepting edge
  // with valid still high, so a following request can go back to back.
  task automatic send_item(in_item_t it, int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, hold until every queued reply came back, then rest.
  task automatic drain_and_rest();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (REST_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [CFG_DATA_W-1:0] sz, nb, ba;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset setup is 16-byte blocks, 1024 of them at 0x10000.
    send_item(alloc_item(0), next_gap());               // fresh block 0
    send_item(alloc_item(16), next_gap());              // fresh block 1
    send_item(alloc_item(17), next_gap());              // one byte too many
    send_item(alloc_item(65536), next_gap());           // largest request
    send_item(free_item('0), next_gap());               // null address
    send_item(free_item(RST_BASE + 8), next_gap());     // off a block boundary
    send_item(free_item(RST_BASE - 16), next_gap());    // below the pool
    send_item(free_item(RST_BASE + 16384), next_gap()); // just past the pool
    send_item(free_item('1), next_gap());               // top of the address space
    send_item(free_item(RST_BASE + 16), next_gap());    // push block 1
    send_item(alloc_item(8), next_gap());               // pop block 1 again
    send_item(free_item(RST_BASE), next_gap());
    send_item(free_item(RST_BASE), next_gap());         // double free, goes unnoticed
    send_item(free_item(RST_BASE + 16), next_gap());    // none left in use
    drain_and_rest();

    // Empty pool: every allocate exhausts, every free is out of range.
    write_reg(CFG_ACTIVE, 0);
    send_item(alloc_item(1), next_gap());
    send_item(free_item(RST_BASE), next_gap());
    drain_and_rest();

    // Size zero, oversize block count saturating, pool at address zero.
    write_reg(CFG_REQ_SIZE, 0);
    write_reg(CFG_ACTIVE, 2047);
    write_reg(CFG_BASE, 0);
    send_item(alloc_item(16), next_gap());
    send_item(alloc_item(0), next_gap());
    send_item(free_item('0), next_gap());               // block 0 is unfreeable here
    send_item(free_item(16), next_gap());
    drain_and_rest();

    // Resize without reinit: the popped index is placed at the new stride.
    write_reg(CFG_REQ_SIZE, 100);
    send_item(alloc_item(112), next_gap());
    send_item(alloc_item(113), next_gap());
    drain_and_rest();

    // Move the base to the top: the next fresh block wraps past 2^32.
    write_reg(CFG_BASE, 32'hFFFF_FFF0);
    send_item(alloc_item(5), next_gap());
    send_item(free_item(32'h0000_00D0), next_gap());    // wrapped block is rejected
    send_item(free_item(32'hFFFF_FFF0), next_gap());
    drain_and_rest();

    // Random phases, each under its own pool setup.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin sz = 16;    nb = 1024; ba = RST_BASE;      end
        1: begin sz = 1;     nb = 4;    ba = 32'h0000_1000; end
        2: begin sz = 65536; nb = 3;    ba = 32'h0010_0000; end
        3: begin sz = 4000;  nb = 12;   ba = 32'hFFFF_8000; end // wraps at block 9
        4: begin sz = 0;     nb = 2047; ba = 0;             end
        5: begin sz = 7;     nb = 1;    ba = 32'hFFFF_FFF0; end
        default: begin
          sz = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 256)
                                           : $urandom_range(0, 65536);
          nb = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 40)
                                           : $urandom_range(0, 2047);
          ba = {28'($urandom_range(0, 32'h0FFF_FFFF)), 4'h0};
        end
      endcase
      write_reg(CFG_REQ_SIZE, sz);
      write_reg(CFG_ACTIVE, nb);
      write_reg(CFG_BASE, ba);
      allocs_sent = 0;
      burst_mode  = (p % 5 == 2);
      out_calm   <= (p % 5 == 3);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) begin
          // Pause until the pipe is empty; keep the pool contents. Odd phases change
          // the stride, even phases from 6 on the base, under the live blocks.
          drain_and_rest();
          if (p % 2 == 1)  write_reg(CFG_REQ_SIZE, $urandom_range(0, 512));
          else if (p >= 6) write_reg(CFG_BASE, {28'($urandom_range(0, 32'h0FFF_FFFF)), 4'h0});
        end
        send_item(random_item(), next_gap());
      end
      drain_and_rest();
    end

    if (sb.pending() != 0)
      $display("%0d replies never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin : watchdog
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
